FILE: rtl/json_action_object_framer_assert.svh
// Assertion macros for the JSON action object framer checker.
// Clock i_clk and reset i_rst_n must be visible where these are used.
`ifndef JSON_ACTION_OBJECT_FRAMER_ASSERT_SVH
`define JSON_ACTION_OBJECT_FRAMER_ASSERT_SVH

// same-cycle implication, masked during reset
`define JAOF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jaof assertion failed");

// next-cycle implication, masked during reset
`define JAOF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jaof assertion failed");

// next-cycle implication that also holds across reset
`define JAOF_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("jaof assertion failed");

`endif

FILE: rtl/jaof_pkg.sv
// Shared types and constants of the JSON action object framer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package jaof_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int KEPT_W    = $clog2(BUF_BYTES);
    localparam int LEVEL_W   = 16;
    localparam int LEN_W     = 12;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_FINISH,
        OP_RESET,
        OP_IGNORE
    } t_op;

    typedef enum logic [2:0] {
        PH_INIT   = 3'd0,
        PH_FIND   = 3'd1,
        PH_ARRAY  = 3'd2,
        PH_OBJECT = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERROR  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_ELEMENT  = 3'd1,
        EV_TOPOBJ   = 3'd2,
        EV_ARRAY    = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_INCOMPL  = 3'd5,
        EV_FINISH   = 3'd6,
        EV_IGNORED  = 3'd7
    } t_event;

    typedef struct packed {
        logic is_lbrace;
        logic is_rbrace;
        logic is_lbrack;
        logic is_rbrack;
        logic is_quote;
        logic is_bslash;
    } t_char_class;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data_byte;
        t_char_class cls;
    } t_class_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             stored;
        logic             in_object;
        t_event           event_res;
        logic [LEN_W-1:0] obj_length;
    } t_result;

endpackage

FILE: rtl/jaof_front.sv
// Front end: accepts requests, decodes the command and classifies the byte.
// Holds classified requests in a short queue for the back end; uses jaof_pkg.
`timescale 1ns / 1ps

module jaof_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [1:0]            i_cmd,
    input  logic [7:0]            i_data_byte,
    output logic                  o_item_valid,
    input  logic                  i_item_ready,
    output jaof_pkg::t_class_item o_item
);

    jaof_pkg::t_class_item r_mem [jaof_pkg::QDEPTH];
    logic [jaof_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [jaof_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [jaof_pkg::QCNT_W-1:0] r_count;
    logic [jaof_pkg::QCNT_W-1:0] n_count;

    jaof_pkg::t_class_item w_item;
    logic w_wr;
    logic w_rd;

    always_comb begin
        unique case (i_cmd)
            jaof_pkg::CMD_BYTE:   w_item.op = jaof_pkg::OP_BYTE;
            jaof_pkg::CMD_FINISH: w_item.op = jaof_pkg::OP_FINISH;
            jaof_pkg::CMD_RESET:  w_item.op = jaof_pkg::OP_RESET;
            default:              w_item.op = jaof_pkg::OP_IGNORE;
        endcase
        w_item.data_byte     = i_data_byte;
        w_item.cls.is_lbrace = (i_data_byte == jaof_pkg::CH_LBRACE);
        w_item.cls.is_rbrace = (i_data_byte == jaof_pkg::CH_RBRACE);
        w_item.cls.is_lbrack = (i_data_byte == jaof_pkg::CH_LBRACK);
        w_item.cls.is_rbrack = (i_data_byte == jaof_pkg::CH_RBRACK);
        w_item.cls.is_quote  = (i_data_byte == jaof_pkg::CH_QUOTE);
        w_item.cls.is_bslash = (i_data_byte == jaof_pkg::CH_BSLASH);
    end

    assign o_full       = (r_count == jaof_pkg::QCNT_W'(jaof_pkg::QDEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_wr         = i_push && !o_full;
    assign w_rd         = o_item_valid && i_item_ready;

    always_comb begin
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

FILE: rtl/jaof_back.sv
// Back end: phase state machine, quote/escape tracking and depth counters.
// Consumes one classified request a cycle while the result queue has room; uses jaof_pkg.
`timescale 1ns / 1ps

module jaof_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  jaof_pkg::t_class_item i_item,
    input  logic                  i_out_full,
    output logic                  o_out_wr,
    output jaof_pkg::t_result     o_result
);

    jaof_pkg::t_phase r_phase;
    jaof_pkg::t_phase n_phase;
    logic [jaof_pkg::LEVEL_W-1:0] r_brace;
    logic [jaof_pkg::LEVEL_W-1:0] n_brace;
    logic [jaof_pkg::LEVEL_W-1:0] r_bracket;
    logic [jaof_pkg::LEVEL_W-1:0] n_bracket;
    logic [jaof_pkg::KEPT_W-1:0]  r_kept;
    logic [jaof_pkg::KEPT_W-1:0]  n_kept;
    logic [jaof_pkg::KEPT_W-1:0]  r_offset;
    logic [jaof_pkg::KEPT_W-1:0]  n_offset;
    logic r_open;
    logic n_open;
    logic r_quotes;
    logic n_quotes;
    logic r_escape;
    logic n_escape;

    localparam logic [jaof_pkg::KEPT_W-1:0] KeptMax = jaof_pkg::KEPT_W'(jaof_pkg::BUF_BYTES - 1);

    logic w_take;
    logic w_live;
    logic w_buf_full;
    logic w_bs_open;
    logic w_quote_new;
    logic w_struct;
    logic w_keep;
    logic w_close;
    logic [jaof_pkg::LEVEL_W-1:0] w_brace_inc;
    logic [jaof_pkg::LEVEL_W-1:0] w_brace_dec;
    logic [jaof_pkg::LEVEL_W-1:0] w_bracket_inc;
    logic [jaof_pkg::LEVEL_W-1:0] w_bracket_dec;
    logic [jaof_pkg::KEPT_W-1:0]  w_kept_inc;
    logic [jaof_pkg::KEPT_W-1:0]  w_len;
    jaof_pkg::t_event w_event;

    assign o_item_ready = !i_out_full;
    assign w_take       = i_item_valid && !i_out_full;
    assign o_out_wr     = w_take;

    assign w_live = (r_phase == jaof_pkg::PH_INIT) || (r_phase == jaof_pkg::PH_FIND)
                 || (r_phase == jaof_pkg::PH_ARRAY) || (r_phase == jaof_pkg::PH_OBJECT);
    assign w_buf_full    = (r_kept >= KeptMax);
    assign w_bs_open     = !r_escape && i_item.cls.is_bslash && r_quotes;
    assign w_quote_new   = r_quotes ^ i_item.cls.is_quote;
    // structural byte: outside strings and not escaped, so braces count
    assign w_struct      = !r_escape && !w_bs_open && !w_quote_new;
    assign w_brace_inc   = r_brace + 1'b1;
    assign w_brace_dec   = r_brace - 1'b1;
    assign w_bracket_inc = r_bracket + 1'b1;
    assign w_bracket_dec = r_bracket - 1'b1;
    assign w_kept_inc    = r_kept + 1'b1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (i_item.op)
            jaof_pkg::OP_FINISH: n_phase = jaof_pkg::PH_DONE;
            jaof_pkg::OP_RESET:  n_phase = jaof_pkg::PH_INIT;
            jaof_pkg::OP_IGNORE: n_phase = r_phase;
            jaof_pkg::OP_BYTE: begin
                if (w_live && w_buf_full) begin
                    n_phase = jaof_pkg::PH_ERROR;
                end else if (w_live && w_struct) begin
                    unique case (r_phase)
                        jaof_pkg::PH_INIT: begin
                            if (i_item.cls.is_lbrace) begin
                                n_phase = jaof_pkg::PH_FIND;
                            end
                        end
                        jaof_pkg::PH_FIND: begin
                            if (i_item.cls.is_lbrack) begin
                                n_phase = jaof_pkg::PH_ARRAY;
                            end else if (i_item.cls.is_rbrace && w_brace_dec == '0) begin
                                n_phase = jaof_pkg::PH_DONE;
                            end
                        end
                        jaof_pkg::PH_ARRAY: begin
                            if (i_item.cls.is_lbrace) begin
                                if (w_brace_inc == jaof_pkg::LEVEL_W'(2)) begin
                                    n_phase = jaof_pkg::PH_OBJECT;
                                end
                            end else if (i_item.cls.is_rbrack && w_bracket_dec == '0) begin
                                n_phase = jaof_pkg::PH_DONE;
                            end
                        end
                        jaof_pkg::PH_OBJECT: begin
                            if (i_item.cls.is_rbrace && w_brace_dec == jaof_pkg::LEVEL_W'(1)) begin
                                n_phase = jaof_pkg::PH_ARRAY;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end
            end
            default: n_phase = r_phase;
        endcase
    end

    // counters, string state and result
    always_comb begin
        n_brace   = r_brace;
        n_bracket = r_bracket;
        n_offset  = r_offset;
        n_open    = r_open;
        n_quotes  = r_quotes;
        n_escape  = r_escape;
        w_keep    = 1'b0;
        w_close   = 1'b0;
        w_event   = jaof_pkg::EV_NONE;
        w_len     = '0;
        case (i_item.op)
            jaof_pkg::OP_FINISH: begin
                w_event = (r_phase == jaof_pkg::PH_OBJECT && r_open) ? jaof_pkg::EV_INCOMPL
                                                                     : jaof_pkg::EV_FINISH;
            end
            jaof_pkg::OP_RESET: begin
                n_brace   = '0;
                n_bracket = '0;
                n_offset  = '0;
                n_open    = 1'b0;
                n_quotes  = 1'b0;
                n_escape  = 1'b0;
            end
            jaof_pkg::OP_BYTE: begin
                if (!w_live) begin
                    w_event = jaof_pkg::EV_IGNORED;
                end else if (w_buf_full) begin
                    w_event = jaof_pkg::EV_OVERFLOW;
                end else if (r_escape) begin
                    n_escape = 1'b0;
                    w_keep   = 1'b1;
                end else if (w_bs_open) begin
                    n_escape = 1'b1;
                    w_keep   = 1'b1;
                end else begin
                    n_quotes = w_quote_new;
                    if (w_quote_new) begin
                        w_keep = 1'b1;
                    end else begin
                        case (r_phase)
                            jaof_pkg::PH_INIT: begin
                                if (i_item.cls.is_lbrace) begin
                                    n_brace = jaof_pkg::LEVEL_W'(1);
                                    w_keep  = 1'b1;
                                end
                            end
                            jaof_pkg::PH_FIND: begin
                                w_keep = 1'b1;
                                if (i_item.cls.is_lbrack) begin
                                    n_bracket = w_bracket_inc;
                                end else if (i_item.cls.is_lbrace) begin
                                    n_brace = w_brace_inc;
                                end else if (i_item.cls.is_rbrace) begin
                                    n_brace = w_brace_dec;
                                    if (w_brace_dec == '0) begin
                                        w_event = jaof_pkg::EV_TOPOBJ;
                                        w_len   = w_kept_inc;
                                    end
                                end
                            end
                            jaof_pkg::PH_ARRAY: begin
                                if (i_item.cls.is_lbrace) begin
                                    n_brace = w_brace_inc;
                                    if (w_brace_inc == jaof_pkg::LEVEL_W'(2)) begin
                                        n_offset = r_kept;
                                        n_open   = 1'b1;
                                        w_keep   = 1'b1;
                                    end
                                end else if (i_item.cls.is_rbrack) begin
                                    n_bracket = w_bracket_dec;
                                    if (w_bracket_dec == '0) begin
                                        w_event = jaof_pkg::EV_ARRAY;
                                    end
                                end
                            end
                            default: begin
                                w_keep = 1'b1;
                                if (i_item.cls.is_lbrace) begin
                                    n_brace = w_brace_inc;
                                end else if (i_item.cls.is_rbrace) begin
                                    n_brace = w_brace_dec;
                                    if (w_brace_dec == jaof_pkg::LEVEL_W'(1)) begin
                                        // element closed: report and restart the buffer
                                        w_event  = jaof_pkg::EV_ELEMENT;
                                        w_len    = w_kept_inc - r_offset;
                                        w_close  = 1'b1;
                                        n_offset = '0;
                                        n_open   = 1'b0;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            default: w_event = jaof_pkg::EV_IGNORED;
        endcase

        if (i_item.op == jaof_pkg::OP_RESET || w_close) begin
            n_kept = '0;
        end else if (w_keep) begin
            n_kept = w_kept_inc;
        end else begin
            n_kept = r_kept;
        end

        o_result.out_byte   = i_item.data_byte;
        o_result.stored     = w_keep;
        o_result.in_object  = w_keep && (r_phase == jaof_pkg::PH_OBJECT
                                         || n_phase == jaof_pkg::PH_OBJECT);
        o_result.event_res  = w_event;
        o_result.obj_length = jaof_pkg::LEN_W'(w_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= jaof_pkg::PH_INIT;
            r_brace   <= '0;
            r_bracket <= '0;
            r_kept    <= '0;
            r_offset  <= '0;
            r_open    <= 1'b0;
            r_quotes  <= 1'b0;
            r_escape  <= 1'b0;
        end else if (w_take) begin
            r_phase   <= n_phase;
            r_brace   <= n_brace;
            r_bracket <= n_bracket;
            r_kept    <= n_kept;
            r_offset  <= n_offset;
            r_open    <= n_open;
            r_quotes  <= n_quotes;
            r_escape  <= n_escape;
        end
    end

endmodule

FILE: rtl/jaof_out_queue.sv
// Result queue: holds finished results until the receiver pops them.
// Written by the back end; uses jaof_pkg.
`timescale 1ns / 1ps

module jaof_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  jaof_pkg::t_result i_wr_data,
    output logic              o_full,
    output logic              o_empty,
    input  logic              i_pop,
    output jaof_pkg::t_result o_rd_data
);

    jaof_pkg::t_result r_mem [jaof_pkg::QDEPTH];
    logic [jaof_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [jaof_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [jaof_pkg::QCNT_W-1:0] r_count;
    logic [jaof_pkg::QCNT_W-1:0] n_count;
    logic w_wr;
    logic w_rd;

    assign o_full    = (r_count == jaof_pkg::QCNT_W'(jaof_pkg::QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign w_wr      = i_wr && !o_full;
    assign w_rd      = i_pop && !o_empty;

    always_comb begin
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: rtl/json_action_object_framer.sv
// JSON action object framer, top level: front end, back end and result queue.
// Depends on jaof_pkg, jaof_front, jaof_back and jaof_out_queue.
//
// Input channel: drive i_cmd / i_data_byte and raise push; the request is
// taken at an edge where push is high and full is low. Commands are stream
// byte, end of stream and parser reset; the unused code is reported ignored.
// Result channel: while empty is low the oldest result sits on the o_ ports;
// raise pop to take it. Every request yields exactly one result.
// Path: a request goes through the front queue, the back end and the result
// queue to the result ports. Throughput is one request per cycle while the
// result queue has room, set by the phase and counter update in the back end.
// Stalls: both sides have a four-entry queue; while the receiver holds off,
// results collect in the result queue, then the back end stalls, then the
// front queue fills and full rises.
// Reset (i_rst_n low, synchronous) empties both queues and returns the parser
// to its init phase; the reset command does the same to the parser state only.
`timescale 1ns / 1ps

module json_action_object_framer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_cmd,
    input  logic [7:0]                  i_data_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  o_out_byte,
    output logic                        o_stored,
    output logic                        o_in_object,
    output logic [2:0]                  o_event_res,
    output logic [jaof_pkg::LEN_W-1:0]  o_obj_length
);

    logic                  w_item_valid;
    logic                  w_item_ready;
    jaof_pkg::t_class_item w_item;
    logic                  w_out_full;
    logic                  w_out_wr;
    jaof_pkg::t_result     w_result;
    jaof_pkg::t_result     w_head;

    jaof_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    jaof_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .i_out_full   (w_out_full),
        .o_out_wr     (w_out_wr),
        .o_result     (w_result)
    );

    jaof_out_queue u_out_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_out_wr),
        .i_wr_data (w_result),
        .o_full    (w_out_full),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_rd_data (w_head)
    );

    assign o_out_byte   = w_head.out_byte;
    assign o_stored     = w_head.stored;
    assign o_in_object  = w_head.in_object;
    assign o_event_res  = w_head.event_res;
    assign o_obj_length = w_head.obj_length;

endmodule

FILE: rtl/jaof_checker.sv
// Port-level checks for the JSON action object framer, bound to the top level.
// Depends on jaof_pkg and json_action_object_framer_assert.svh.
`timescale 1ns / 1ps
`include "json_action_object_framer_assert.svh"

module jaof_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic [1:0]                 i_cmd,
    input logic [7:0]                 i_data_byte,
    input logic                       empty,
    input logic                       pop,
    input logic [7:0]                 o_out_byte,
    input logic                       o_stored,
    input logic                       o_in_object,
    input logic [2:0]                 o_event_res,
    input logic [jaof_pkg::LEN_W-1:0] o_obj_length
);

    // reset drains both queues
    `JAOF_ASSERT_ALWAYS(a_reset_drains, !i_rst_n, empty && !full)

    // only a stored byte can belong to an element
    `JAOF_ASSERT_NOW(a_in_object_stored, !empty && o_in_object, o_stored)

    // a closed element is always its own closing brace, stored inside the object
    `JAOF_ASSERT_NOW(a_element_stored, !empty && o_event_res == jaof_pkg::EV_ELEMENT,
        o_stored && o_in_object)

    // a length is reported only with an object-done event
    `JAOF_ASSERT_NOW(a_length_only_done,
        !empty && o_event_res != jaof_pkg::EV_ELEMENT && o_event_res != jaof_pkg::EV_TOPOBJ,
        o_obj_length == '0)

    // a waiting result stays until it is popped
    `JAOF_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(o_out_byte))

endmodule

bind json_action_object_framer jaof_checker u_jaof_checker (.*);
